// ----- hw/rtl/dsc_pkg.sv -----
// Package for the stencil coefficient block: payload structs, controller
// states, register indexes and command/status types. No dependencies.
package dsc_pkg;

  typedef struct packed {
    logic [31:0] dzt_south;
    logic [31:0] dzt_mid;
    logic [31:0] dzt_north;
    logic [7:0]  kmt_south;
    logic [7:0]  kmt_mid;
    logic [7:0]  kmt_north;
    logic signed [31:0] dtn;
    logic signed [31:0] dts;
    logic signed [31:0] dte;
    logic signed [31:0] dtw;
    logic        row_in_range;
  } req_t;

  typedef struct packed {
    logic signed [31:0] coef_north;
    logic signed [31:0] coef_south;
    logic signed [31:0] coef_east;
    logic signed [31:0] coef_west;
    logic signed [31:0] coef_center;
    logic [7:0]  column_index;
    logic        row_done;
  } rsp_t;

  localparam logic [1:0] RegColFirst  = 2'd0;
  localparam logic [1:0] RegColLast   = 2'd1;
  localparam logic [1:0] RegRowLength = 2'd2;
  localparam logic [1:0] RegLevel     = 2'd3;

  typedef enum logic [2:0] {
    StIdle, StDiv, StEmit, StEmitLast
  } state_e;

  typedef struct packed {
    logic capture;   // latch request, start sides
    logic step;      // one multiply or divider iteration
    logic emit_col;  // present column c-1 result
    logic emit_last; // present last column zero result
    logic commit;    // shift the window
  } cmd_t;

  typedef struct packed {
    logic has_prev;
    logic is_last;
    logic div_done;
  } sts_t;

endpackage

// ----- hw/rtl/diffusion_stencil_coefficients.sv -----
// Five-point stencil coefficient generator, one grid column per request.
// The four side coefficients share one 32x32 multiplier and a
// one-bit-per-cycle 64-bit restoring divider. Each side takes one multiply
// and 64 divide steps. The controller sees the divider finish through its
// registered busy flag. The input is stalled from acceptance until the
// last result of that request leaves: the first column of a row gives no
// result, a middle column one and the last column two. A result that the
// receiver stalls holds off the next acceptance.
// Registers are written through the plain cfg port
// (0 col_first, 1 col_last, 2 row_length, 3 level).
module diffusion_stencil_coefficients #(
  parameter int MaxRow = 256
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [1:0]    cfg_idx_i,
  input  logic [8:0]    cfg_data_i,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  dsc_pkg::req_t in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output dsc_pkg::rsp_t out_data_o
);
  import dsc_pkg::*;

  cmd_t cmd;
  sts_t sts;

  dsc_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i,
    .sts_i(sts), .cmd_o(cmd)
  );

  dsc_datapath #(.MaxRow(MaxRow)) u_dp (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .req_i(in_data_i), .cmd_i(cmd), .sts_o(sts), .rsp_o(out_data_o)
  );

endmodule

// ----- hw/rtl/dsc_datapath.sv -----
// Datapath: column window, config registers, shared multiplier and a
// restoring divider iterated over the four sides. Uses dsc_pkg.
module dsc_datapath #(
  parameter int MaxRow = 256
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [1:0]    cfg_idx_i,
  input  logic [8:0]    cfg_data_i,
  input  dsc_pkg::req_t req_i,
  input  dsc_pkg::cmd_t cmd_i,
  output dsc_pkg::sts_t sts_o,
  output dsc_pkg::rsp_t rsp_o
);
  import dsc_pkg::*;

  localparam int Lim = (MaxRow < 256) ? MaxRow : 256;
  localparam logic [8:0] LimW = 9'(Lim);

  logic [7:0] col_first_q, col_last_q, level_q;
  logic [8:0] row_length_q;
  logic [7:0] cnt_q;
  logic [31:0] wh_q, ch_q, hs_q, hn_q;
  logic [7:0]  wk_q, ck_q, ks_q, kn_q;
  logic [31:0] dt_q [4];
  logic        act_q;
  req_t        r_q;

  // Divider state
  logic [1:0]  side_q;
  logic [5:0]  bit_q;
  logic        mul_q;
  logic [63:0] num_q;   // magnitude of product, shifted out during division
  logic [31:0] rem_q;
  logic        neg_q;
  logic        busy_q;
  logic signed [32:0] res_q [4];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_first_q <= 8'd2; col_last_q <= 8'd255;
      row_length_q <= 9'd256; level_q <= 8'd1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegColFirst:  col_first_q  <= cfg_data_i[7:0];
        RegColLast:   col_last_q   <= cfg_data_i[7:0];
        RegRowLength: row_length_q <= cfg_data_i;
        RegLevel:     level_q      <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  logic [8:0] len;
  always_comb begin
    len = row_length_q;
    if (len > LimW) len = LimW;
    if (len < 9'd3) len = 9'd3;
  end

  logic [7:0] ci;
  assign ci = cnt_q - 8'd1;
  logic act;
  assign act = act_q && (ci >= 8'd1) && ({1'b0, ci} + 9'd1 >= {1'b0, col_first_q})
             && ({1'b0, ci} + 9'd1 <= {1'b0, col_last_q}) && ({1'b0, ci} <= len - 9'd2);

  logic [31:0] nb;
  always_comb begin
    case (side_q)
      2'd0: nb = hn_q;
      2'd1: nb = hs_q;
      2'd2: nb = r_q.dzt_mid;
      default: nb = wh_q;
    endcase
  end
  logic [31:0] mn, dmag;
  logic        dneg;
  assign mn   = (nb < ch_q) ? nb : ch_q;
  assign dneg = dt_q[side_q][31];
  assign dmag = dneg ? (~dt_q[side_q] + 32'd1) : dt_q[side_q];

  logic [32:0] trial;
  assign trial = {rem_q, num_q[63]} - {1'b0, ch_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0; wh_q <= '0; ch_q <= '0; hs_q <= '0; hn_q <= '0;
      wk_q <= '0; ck_q <= '0; ks_q <= '0; kn_q <= '0; act_q <= 1'b0;
      for (int j = 0; j < 4; j++) dt_q[j] <= '0;
      busy_q <= 1'b0; side_q <= '0; bit_q <= '0; mul_q <= 1'b0;
      r_q <= '0; num_q <= '0; rem_q <= '0; neg_q <= 1'b0;
    end else begin
      if (cmd_i.capture) begin
        r_q <= req_i; busy_q <= 1'b1; side_q <= '0; mul_q <= 1'b1;
      end else if (cmd_i.step && busy_q) begin
        if (mul_q) begin
          num_q <= 64'(dmag) * 64'(mn);
          neg_q <= dneg; rem_q <= '0; bit_q <= '0; mul_q <= 1'b0;
        end else begin
          if (!trial[32]) rem_q <= trial[31:0];
          else rem_q <= {rem_q[30:0], num_q[63]};
          num_q <= {num_q[62:0], ~trial[32]};
          if (bit_q == 6'd63) begin
            mul_q <= 1'b1;
            side_q <= side_q + 2'd1;
            if (side_q == 2'd3) busy_q <= 1'b0;
          end
          bit_q <= bit_q + 6'd1;
        end
      end
      if (cmd_i.emit_last) cnt_q <= '0;
      if (cmd_i.commit) begin
        wh_q <= ch_q; wk_q <= ck_q;
        ch_q <= r_q.dzt_mid; ck_q <= r_q.kmt_mid;
        hs_q <= r_q.dzt_south; hn_q <= r_q.dzt_north;
        ks_q <= r_q.kmt_south; kn_q <= r_q.kmt_north;
        dt_q[0] <= r_q.dtn; dt_q[1] <= r_q.dts;
        dt_q[2] <= r_q.dte; dt_q[3] <= r_q.dtw;
        act_q <= r_q.row_in_range;
        cnt_q <= cnt_q + 8'd1;
      end
    end
  end

  // Quotient of |dt*m|/h fits 33 bits signed since m <= h; capture at end.
  logic [63:0] qfin;
  assign qfin = {num_q[62:0], ~trial[32]};
  always_ff @(posedge clk_i) begin
    if (cmd_i.step && busy_q && !mul_q && bit_q == 6'd63) begin
      res_q[side_q] <= (ch_q == 32'd0) ? 33'sd0 :
        (neg_q ? -$signed({1'b0, qfin[31:0]}) : $signed({1'b0, qfin[31:0]}));
    end
  end

  logic [3:0] keep;
  assign keep[0] = level_q <= kn_q;
  assign keep[1] = level_q <= ks_q;
  assign keep[2] = level_q <= r_q.kmt_mid;
  assign keep[3] = level_q <= wk_q;

  logic signed [34:0] sum;
  logic signed [32:0] s [4];
  logic signed [35:0] ctr;
  always_comb begin
    for (int j = 0; j < 4; j++)
      s[j] = (act && level_q <= ck_q && keep[j]) ? res_q[j] : 33'sd0;
    sum = 35'(s[0]) + 35'(s[1]) + 35'(s[2]) + 35'(s[3]);
    ctr = -36'(sum);
    rsp_o = '0;
    if (cmd_i.emit_col) begin
      rsp_o.coef_north = s[0][31:0];
      rsp_o.coef_south = s[1][31:0];
      rsp_o.coef_east  = s[2][31:0];
      rsp_o.coef_west  = s[3][31:0];
      if (ctr > 36'sd2147483647) rsp_o.coef_center = 32'h7fffffff;
      else if (ctr < -36'sd2147483648) rsp_o.coef_center = 32'h80000000;
      else rsp_o.coef_center = ctr[31:0];
      rsp_o.column_index = ci;
    end else begin
      rsp_o.column_index = cnt_q;
      rsp_o.row_done = 1'b1;
    end
  end

  assign sts_o.has_prev = cnt_q != 8'd0;
  assign sts_o.is_last  = {1'b0, cnt_q} >= len - 9'd1;
  assign sts_o.div_done = !busy_q;

endmodule

// ----- hw/rtl/dsc_ctrl.sv -----
// Controller state machine: sequences capture, divide, emit and window
// shift for one request. Uses dsc_pkg.
module dsc_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  input  dsc_pkg::sts_t sts_i,
  output dsc_pkg::cmd_t cmd_o
);
  import dsc_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= StIdle;
    else state_q <= state_d;
  end

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    in_stall_o = 1'b1;
    out_valid_o = 1'b0;
    case (state_q)
      StIdle: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d = StDiv;
        end
      end
      StDiv: begin
        cmd_o.step = 1'b1;
        if (sts_i.div_done) begin
          cmd_o.step = 1'b0;
          if (sts_i.has_prev) state_d = StEmit;
          else if (sts_i.is_last) state_d = StEmitLast;
          else begin
            cmd_o.commit = 1'b1;
            state_d = StIdle;
          end
        end
      end
      StEmit: begin
        out_valid_o = 1'b1;
        cmd_o.emit_col = 1'b1;
        if (!out_stall_i) begin
          if (sts_i.is_last) state_d = StEmitLast;
          else begin
            cmd_o.commit = 1'b1;
            state_d = StIdle;
          end
        end
      end
      StEmitLast: begin
        out_valid_o = 1'b1;
        cmd_o.emit_last = !out_stall_i;
        if (!out_stall_i) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  a_emit_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_o.emit_col && cmd_o.emit_last)) else $error("both emits");
  a_capture_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.capture |=> state_q == StDiv) else $error("capture not followed");
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o) else $error("accept during emit");

endmodule
